### design/night_battery_charge_sequencer_macros.svh
// Assertion macros for the night battery charge sequencer.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef NIGHT_BATTERY_CHARGE_SEQUENCER_MACROS_SVH
`define NIGHT_BATTERY_CHARGE_SEQUENCER_MACROS_SVH
`ifndef SYNTH
// Consequence must hold in the same cycle as the antecedent.
`define NBCS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nbcs: same-cycle check failed");
// Consequence must hold in the cycle after the antecedent.
`define NBCS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nbcs: next-cycle check failed");
`else
`define NBCS_ASSERT_SAME(label, ante, cons)
`define NBCS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### design/nbcs_pkg.sv
`default_nettype none

package nbcs_pkg;

  localparam int CNT_W = 24;
  localparam int REF_W = 16;

  localparam logic [CNT_W-1:0] CNT_MAX        = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] SETTLE_TICKS   = CNT_W'(1000);
  localparam logic [CNT_W-1:0] VERIFY_TICKS   = CNT_W'(10000);
  localparam logic [CNT_W-1:0] COMPLETE_TICKS = CNT_W'(5000);
  localparam logic [CNT_W-1:0] TICKS_PER_MIN  = CNT_W'(60000);

  localparam logic [3:0] PHASE_DONE  = 4'd9;
  localparam logic [1:0] MAX_RETRIES = 2'd3;

  // -512 and -160, the references used while the converter starts up.
  localparam logic signed [REF_W-1:0] START_POWER_REF   = -16'sd512;
  localparam logic signed [REF_W-1:0] START_CURRENT_REF = -16'sd160;

  typedef enum logic [1:0] {
    CFG_TIME_LIMIT  = 2'd0,
    CFG_POWER_REF   = 2'd1,
    CFG_CURRENT_REF = 2'd2
  } cfg_index_t;

  typedef enum logic [6:0] {
    ST_INIT         = 7'b000_0001,
    ST_CHECK        = 7'b000_0010,
    ST_START_DCDC   = 7'b000_0100,
    ST_START_INV    = 7'b000_1000,
    ST_RESTART_DCDC = 7'b001_0000,
    ST_CHARGE       = 7'b010_0000,
    ST_FAILED       = 7'b100_0000
  } state_t;

  typedef enum logic [2:0] {
    CODE_INIT         = 3'd0,
    CODE_CHECK        = 3'd1,
    CODE_START_DCDC   = 3'd2,
    CODE_START_INV    = 3'd3,
    CODE_RESTART_DCDC = 3'd4,
    CODE_CHARGE       = 3'd5,
    CODE_FAILED       = 3'd6
  } state_code_t;

  // Binary state code as reported on the result channel.
  function automatic logic [2:0] state_code(state_t s);
    logic [2:0] c;
    case (s)
      ST_INIT:         c = CODE_INIT;
      ST_CHECK:        c = CODE_CHECK;
      ST_START_DCDC:   c = CODE_START_DCDC;
      ST_START_INV:    c = CODE_START_INV;
      ST_RESTART_DCDC: c = CODE_RESTART_DCDC;
      ST_CHARGE:       c = CODE_CHARGE;
      ST_FAILED:       c = CODE_FAILED;
      default:         c = CODE_INIT;
    endcase
    return c;
  endfunction

  // Increment that sticks at the counter's top value.
  function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
  endfunction

endpackage

`default_nettype wire

### design/night_battery_charge_sequencer.sv
//  Channel  | Handshake            | Payload
//  ---------+----------------------+---------------------------------------------
//  in       | in_valid / in_ready  | dcdc_running, inverter_running,
//           |                      | protect_power_off, reclose_failed,
//           |                      | dcdc_charge_phase
//  out      | out_valid / out_ready| seq_state, dcdc_enable_cmd, power_ref_*,
//           |                      | current_ref_*, inverter_on_cmd,
//           |                      | generator_off_cmd, profile_switch_req
//  cfg      | cfg_wr_en            | cfg_index, cfg_data (write only, no wait)
//
//  Each status beat produces exactly one result beat: the accepted status beat is held in the
//  input register, and its result is captured in the result register.
//  Throughput is one beat per clock while out_ready does not stall, set by the combinational
//  sequencer update between the input register and the result register.
//  Reset (rst, synchronous) returns the sequencer to init with the entry flag set,
//  clears counters and config registers. A stall on out_ready backs up through
//  the input register to in_ready; no beat is dropped or repeated.
`default_nettype none

`include "night_battery_charge_sequencer_macros.svh"

module night_battery_charge_sequencer (
  input  logic                                clk,
  input  logic                                rst,
  // Status ticks.
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                dcdc_running,
  input  logic                                inverter_running,
  input  logic                                protect_power_off,
  input  logic                                reclose_failed,
  input  logic [3:0]                          dcdc_charge_phase,
  // Results.
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [2:0]                          seq_state,
  output logic                                dcdc_enable_cmd,
  output logic                                power_ref_load,
  output logic signed [nbcs_pkg::REF_W-1:0]   power_ref_value,
  output logic                                current_ref_load,
  output logic signed [nbcs_pkg::REF_W-1:0]   current_ref_value,
  output logic                                inverter_on_cmd,
  output logic                                generator_off_cmd,
  output logic                                profile_switch_req,
  // Configuration writes.
  input  logic                                cfg_wr_en,
  input  logic [1:0]                          cfg_index,
  input  logic [nbcs_pkg::REF_W-1:0]          cfg_data
);

  // Configuration. The time limit is kept already scaled to ticks so the
  // per-beat compare needs no multiplier; the product is taken once at write time.
  logic [nbcs_pkg::CNT_W-1:0]        limit_ticks;
  logic signed [nbcs_pkg::REF_W-1:0] charge_power_ref;
  logic signed [nbcs_pkg::REF_W-1:0] charge_current_ref;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_ticks        <= '0;
      charge_power_ref   <= '0;
      charge_current_ref <= '0;
    end else if (cfg_wr_en) begin
      case (nbcs_pkg::cfg_index_t'(cfg_index))
        nbcs_pkg::CFG_TIME_LIMIT: begin
          limit_ticks <= nbcs_pkg::CNT_W'(cfg_data[7:0]) * nbcs_pkg::TICKS_PER_MIN;
        end
        nbcs_pkg::CFG_POWER_REF: begin
          charge_power_ref <= cfg_data;
        end
        nbcs_pkg::CFG_CURRENT_REF: begin
          charge_current_ref <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  // Input register. It advances whenever the result register can take a beat.
  logic       s1_valid;
  logic       s1_dcdc;
  logic       s1_inv;
  logic       s1_prot;
  logic       s1_recl;
  logic [3:0] s1_phase;
  logic       advance;
  logic       fire;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;
  assign fire     = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_dcdc  <= dcdc_running;
      s1_inv   <= inverter_running;
      s1_prot  <= protect_power_off;
      s1_recl  <= reclose_failed;
      s1_phase <= dcdc_charge_phase;
    end
  end

  // Sequencer state. The entry flag is set whenever the state changed on the
  // previous beat, and it is set out of reset so init takes its entry action.
  nbcs_pkg::state_t           state;
  logic                       entry;
  logic [nbcs_pkg::CNT_W-1:0] tick_count;
  logic [nbcs_pkg::CNT_W-1:0] charge_tick_count;
  logic [1:0]                 retry_count;

  nbcs_pkg::state_t           state_next;
  nbcs_pkg::state_t           forced;
  logic [nbcs_pkg::CNT_W-1:0] tick_count_next;
  logic [nbcs_pkg::CNT_W-1:0] charge_tick_count_next;
  logic [1:0]                 retry_count_next;
  logic [nbcs_pkg::CNT_W-1:0] tick_inc;
  logic [nbcs_pkg::CNT_W-1:0] charge_inc;
  logic [1:0]                 retry_inc;

  logic                              ena_next;
  logic                              pload_next;
  logic signed [nbcs_pkg::REF_W-1:0] pval_next;
  logic                              iload_next;
  logic signed [nbcs_pkg::REF_W-1:0] ival_next;
  logic                              invon_next;
  logic                              genoff_next;
  logic                              req_next;

  always_comb begin
    // Counting states restart their counters on the entry beat.
    tick_inc   = nbcs_pkg::sat_inc(entry ? '0 : tick_count);
    charge_inc = nbcs_pkg::sat_inc(entry ? '0 : charge_tick_count);
    retry_inc  = (retry_count == nbcs_pkg::MAX_RETRIES) ? retry_count : retry_count + 2'd1;

    // A dead converter with no retries left, or any protection trip, overrides
    // the current state before the state's own actions are evaluated.
    forced = state;
    if (!s1_dcdc && retry_count == nbcs_pkg::MAX_RETRIES) begin
      forced = nbcs_pkg::ST_FAILED;
    end
    if (s1_prot || s1_recl) begin
      forced = nbcs_pkg::ST_FAILED;
    end

    state_next             = forced;
    tick_count_next        = tick_count;
    charge_tick_count_next = charge_tick_count;
    retry_count_next       = retry_count;
    ena_next               = 1'b0;
    pload_next             = 1'b0;
    pval_next              = '0;
    iload_next             = 1'b0;
    ival_next              = '0;
    invon_next             = 1'b0;
    genoff_next            = 1'b0;
    req_next               = 1'b0;

    case (forced)
      nbcs_pkg::ST_INIT: begin
        if (entry) begin
          retry_count_next = '0;
          genoff_next      = 1'b1;
        end
        state_next = (s1_dcdc && s1_inv) ? nbcs_pkg::ST_CHARGE : nbcs_pkg::ST_CHECK;
      end
      nbcs_pkg::ST_CHECK: begin
        tick_count_next = tick_inc;
        if (s1_dcdc) begin
          state_next = nbcs_pkg::ST_START_DCDC;
        end else if (tick_inc > nbcs_pkg::SETTLE_TICKS) begin
          tick_count_next = nbcs_pkg::SETTLE_TICKS;
          if (retry_count != nbcs_pkg::MAX_RETRIES) begin
            state_next = nbcs_pkg::ST_START_DCDC;
          end
        end
      end
      nbcs_pkg::ST_START_DCDC: begin
        if (entry) begin
          pload_next = 1'b1;
          pval_next  = nbcs_pkg::START_POWER_REF;
          iload_next = 1'b1;
          ival_next  = nbcs_pkg::START_CURRENT_REF;
          ena_next   = 1'b1;
        end
        tick_count_next = tick_inc;
        if (tick_inc > nbcs_pkg::VERIFY_TICKS) begin
          if (s1_dcdc) begin
            retry_count_next = '0;
            state_next       = nbcs_pkg::ST_START_INV;
          end else begin
            retry_count_next = retry_inc;
            state_next       = nbcs_pkg::ST_CHECK;
          end
        end
      end
      nbcs_pkg::ST_RESTART_DCDC: begin
        ena_next        = entry;
        tick_count_next = tick_inc;
        if (tick_inc > nbcs_pkg::VERIFY_TICKS) begin
          retry_count_next = s1_dcdc ? 2'd0 : retry_inc;
          state_next       = nbcs_pkg::ST_CHARGE;
        end
      end
      nbcs_pkg::ST_START_INV: begin
        invon_next      = !s1_inv;
        tick_count_next = tick_inc;
        if (s1_inv) begin
          state_next = nbcs_pkg::ST_CHARGE;
        end
        req_next = (tick_inc > limit_ticks);
      end
      nbcs_pkg::ST_CHARGE: begin
        if (entry) begin
          pload_next = 1'b1;
          pval_next  = charge_power_ref;
          iload_next = 1'b1;
          ival_next  = charge_current_ref;
        end
        tick_count_next        = tick_inc;
        charge_tick_count_next = charge_inc;
        if (!s1_dcdc && retry_count != nbcs_pkg::MAX_RETRIES) begin
          state_next = nbcs_pkg::ST_RESTART_DCDC;
        end
        if (tick_inc > nbcs_pkg::COMPLETE_TICKS) begin
          tick_count_next = nbcs_pkg::COMPLETE_TICKS;
          if (s1_phase == nbcs_pkg::PHASE_DONE) begin
            req_next = 1'b1;
          end
        end
        if (charge_inc > limit_ticks) begin
          req_next = 1'b1;
        end
      end
      nbcs_pkg::ST_FAILED: begin
        // The entry flag looks at the state before the override, so the
        // profile request follows one beat after a forced jump.
        req_next = entry;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= nbcs_pkg::ST_INIT;
      entry             <= 1'b1;
      tick_count        <= '0;
      charge_tick_count <= '0;
      retry_count       <= '0;
    end else if (fire) begin
      state             <= state_next;
      entry             <= (state_next != state);
      tick_count        <= tick_count_next;
      charge_tick_count <= charge_tick_count_next;
      retry_count       <= retry_count_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      seq_state          <= nbcs_pkg::state_code(state_next);
      dcdc_enable_cmd    <= ena_next;
      power_ref_load     <= pload_next;
      power_ref_value    <= pval_next;
      current_ref_load   <= iload_next;
      current_ref_value  <= ival_next;
      inverter_on_cmd    <= invon_next;
      generator_off_cmd  <= genoff_next;
      profile_switch_req <= req_next;
    end
  end

  // Failed is left only through reset.
  `NBCS_ASSERT_NEXT(a_failed_sticks, state == nbcs_pkg::ST_FAILED, state == nbcs_pkg::ST_FAILED)
  // A protection trip always reports the failed state.
  `NBCS_ASSERT_NEXT(a_trip_fails, fire && (s1_prot || s1_recl), seq_state == nbcs_pkg::CODE_FAILED)
  // A stopped converter with all retries spent reports the failed state.
  `NBCS_ASSERT_NEXT(a_retry_spent, fire && !s1_dcdc && retry_count == nbcs_pkg::MAX_RETRIES, seq_state == nbcs_pkg::CODE_FAILED)
  // The converter enable only appears while starting or restarting it.
  `NBCS_ASSERT_SAME(a_enable_state, out_valid && dcdc_enable_cmd, seq_state == nbcs_pkg::CODE_START_DCDC || seq_state == nbcs_pkg::CODE_RESTART_DCDC)

endmodule

`default_nettype wire
